FILE: src/ssidf_pkg.sv
// ----------------------------------------------------------------------------
// ssidf_pkg: shared types and codes for the small key set
// Request and status codes, field widths and the per-cell control group.
// ----------------------------------------------------------------------------
package ssidf_pkg;

	localparam int KEY_IN_W = 32;
	localparam int POS_W    = 6;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic live;
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

FILE: src/ssidf_intf.sv
// ----------------------------------------------------------------------------
// ssidf_intf: request and response channels of the small key set
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ssidf_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          req_type;
	logic signed [ssidf_pkg::KEY_IN_W-1:0] key;

	modport source (output valid, output req_type, output key, input ready);
	modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface ssidf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [ssidf_pkg::POS_W-1:0]   position;

	modport source (output valid, output status, output position, input ready);
	modport sink   (input valid, input status, input position, output ready);
endinterface

FILE: src/ssidf_cell.sv
// ----------------------------------------------------------------------------
// ssidf_cell: one storage cell of the key chain
// Holds one key, compares it with the request key, loads the request key on
// an add and takes its upper neighbour's key when the chain closes a gap.
// ----------------------------------------------------------------------------
module ssidf_cell #(
	parameter int KEY_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ssidf_pkg::cell_ctrl_t   ctrl,
	input  logic [KEY_WIDTH-1:0]    req_key,
	input  logic [KEY_WIDTH-1:0]    next_key,
	output logic [KEY_WIDTH-1:0]    cell_key,
	output logic                    hit_s1
);

	logic [KEY_WIDTH-1:0] key_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= req_key;
		end else if (ctrl.shift) begin
			key_q <= next_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else begin
			hit_s1 <= ctrl.live && (key_q == req_key);
		end
	end

	assign cell_key = key_q;

endmodule

FILE: src/ssidf_encoder.sv
// ----------------------------------------------------------------------------
// ssidf_encoder: hit vector to position
// Turns the per-cell hit flags into a found flag and a binary index.
// ----------------------------------------------------------------------------
module ssidf_encoder #(
	parameter int N     = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [N-1:0]     hit,
	output logic             found_s2,
	output logic [IDX_W-1:0] idx_s2
);

	logic [IDX_W-1:0] idx;

	always_comb begin
		idx = '0;
		for (int i = 0; i < N; i++) begin
			if (hit[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_s2 <= 1'b0;
			idx_s2   <= '0;
		end else begin
			found_s2 <= |hit;
			idx_s2   <= idx;
		end
	end

endmodule

FILE: src/small_set_insert_delete_find.sv
// ----------------------------------------------------------------------------
// small_set_insert_delete_find: bounded key set in insertion order
// A request on req adds, removes or looks up one key; each request gives
// exactly one response on rsp with a status and the key's position.
//   Status: ok, already present, not present, set full.
//   Keys live in a chain of cells; a removal moves every later key down one
//   cell so the set stays packed from cell 0.
// Timing: a request is taken in the idle state, the cells compare it in the
//   next cycle, the hit vector is encoded in the one after, and the update
//   and response register are written in the update step. The set takes no
//   new request until the current one has left its update step, after the
//   compare, encode and update steps through the cell chain.
// Stall: a waiting response does not block the next request; a finished
//   request holds in its update step until the response register is free.
// Reset: the set is empty and no response is pending. Cell contents are
//   not cleared; only cells below the fill count are ever compared.
// ----------------------------------------------------------------------------
module small_set_insert_delete_find #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	ssidf_req_if.sink        req,
	ssidf_rsp_if.source      rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_ENC, S_APPLY} state_t;

	state_t                      state_q;
	logic [1:0]                  op_q;
	logic [KEY_WIDTH-1:0]        key_q;
	logic [CNT_W-1:0]            count_q;
	logic                        rsp_valid_q;
	logic [1:0]                  status_q;
	logic [ssidf_pkg::POS_W-1:0] position_q;

	logic [CAPACITY-1:0]         hit_s1;
	logic                        found_s2;
	logic [IDX_W-1:0]            idx_s2;
	logic [KEY_WIDTH-1:0]        cell_key [CAPACITY];

	logic                        go;
	logic                        full;
	logic                        add_ok;
	logic                        rm_ok;
	logic [1:0]                  status_d;
	logic [ssidf_pkg::POS_W-1:0] position_d;

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.position = position_q;

	assign go     = (state_q == S_APPLY) && (!rsp_valid_q || rsp.ready);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign add_ok = (op_q == ssidf_pkg::OP_ADD) && !full && !found_s2;
	assign rm_ok  = (op_q == ssidf_pkg::OP_REMOVE) && found_s2;

	always_comb begin
		status_d   = ssidf_pkg::ST_ABSENT;
		position_d = '0;
		case (op_q)
			ssidf_pkg::OP_ADD: begin
				if (full) begin
					status_d = ssidf_pkg::ST_FULL;
				end else if (found_s2) begin
					status_d = ssidf_pkg::ST_PRESENT;
				end else begin
					status_d   = ssidf_pkg::ST_OK;
					position_d = ssidf_pkg::POS_W'(count_q);
				end
			end
			ssidf_pkg::OP_REMOVE, ssidf_pkg::OP_FIND: begin
				if (found_s2) begin
					status_d   = ssidf_pkg::ST_OK;
					position_d = ssidf_pkg::POS_W'(idx_s2);
				end
			end
			default: begin
				status_d = ssidf_pkg::ST_ABSENT;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ssidf_pkg::cell_ctrl_t ctrl;
		logic [KEY_WIDTH-1:0]  next_key;

		assign ctrl.live  = (CNT_W'(i) < count_q);
		assign ctrl.load  = go && add_ok && (CNT_W'(i) == count_q);
		assign ctrl.shift = go && rm_ok && (IDX_W'(i) >= idx_s2)
			&& (CNT_W'(i + 1) < count_q);

		if (i + 1 < CAPACITY) begin : g_mid
			assign next_key = cell_key[i + 1];
		end else begin : g_end
			assign next_key = cell_key[i];
		end

		ssidf_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.req_key (key_q),
			.next_key(next_key),
			.cell_key(cell_key[i]),
			.hit_s1  (hit_s1[i])
		);
	end

	ssidf_encoder #(
		.N    (CAPACITY),
		.IDX_W(IDX_W)
	) u_encoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.hit     (hit_s1),
		.found_s2(found_s2),
		.idx_s2  (idx_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= ssidf_pkg::OP_FIND;
			key_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= ssidf_pkg::ST_OK;
			position_q  <= '0;
		end else begin
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.req_type;
						key_q   <= KEY_WIDTH'(req.key);
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_ENC;
				end
				S_ENC: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (go) begin
						status_q    <= status_d;
						position_q  <= position_d;
						if (add_ok) begin
							count_q <= count_q + CNT_W'(1);
						end else if (rm_ok) begin
							count_q <= count_q - CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_s1))
		else $error("key held in more than one cell");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		go && add_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("successful add did not grow the set");

	a_rsp_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> rsp_valid_q && (state_q == S_IDLE))
		else $error("update step gave no response");
`endif

endmodule
